>>> rtl/core/rdsm_pkg.sv
package rdsm_pkg;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;

  localparam logic [1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef struct packed {
    logic       fire;
    logic       is_char;
    logic [7:0] ch;
  } step_t;

endpackage

>>> rtl/core/rdsm_cell.sv
module rdsm_cell
  import rdsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  step_t      step,
  input  logic       enable,
  input  logic       has_prev,
  input  logic [7:0] pat_char,
  input  logic [7:0] prev_char,
  input  logic       left_state,
  input  logic       left2_next,
  output logic       state,
  output logic       state_next
);

  logic hit;
  logic prev_hit;
  logic b;

  always_comb begin
    hit      = (pat_char == DOT_CHAR) || (pat_char == step.ch);
    prev_hit = (prev_char == DOT_CHAR) || (prev_char == step.ch);
    if (pat_char == STAR_CHAR) begin
      b = has_prev && (left2_next || (step.is_char && prev_hit && state));
    end else begin
      b = step.is_char && hit && left_state;
    end
    state_next = enable && b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= 1'b0;
    end else if (step.fire) begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/regex_dot_star_matcher.sv
// The result word of an accepted word appears on the master side in the next cycle.
// Throughput: one word per cycle unless the output stalls; the whole prefix vector
// is updated by a row of one-bit cells, with star closures rippling through the row.
// Output is held in a one-deep register; a new word is taken whenever it is empty or drained.
// Reset (rst, synchronous) clears the prefix vector, the pattern registers and the output valid.
module regex_dot_star_matcher
  import rdsm_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_char
  input  logic [0:0]  s_tuser,   // [0] is_char, low for a command word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] matched, [7:1] zero
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [63:0]  pattern_low;
  logic [63:0]  pattern_high;
  logic [4:0]   pattern_length;
  logic [127:0] pat_all;
  logic [LW-1:0] len_sat;
  step_t        step;
  logic [MAX_PATTERN:0] st;
  logic [MAX_PATTERN:0] nv;
  logic         matched;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_PATTERN_LOW:    pattern_low    <= pwdata;
        REG_PATTERN_HIGH:   pattern_high   <= pwdata;
        REG_PATTERN_LENGTH: pattern_length <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_PATTERN_LOW:    prdata = pattern_low;
      REG_PATTERN_HIGH:   prdata = pattern_high;
      REG_PATTERN_LENGTH: prdata = {59'd0, pattern_length};
      default:            prdata = '0;
    endcase
  end

  assign pat_all = {pattern_high, pattern_low};
  assign len_sat = (pattern_length > 5'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
                                                      : LW'(pattern_length);

  assign s_tready     = !m_tvalid || m_tready;
  assign step.fire    = s_tvalid && s_tready;
  assign step.is_char = s_tuser[0];
  assign step.ch      = s_tdata;

  assign nv[0] = !step.is_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0] <= 1'b0;
    end else if (step.fire) begin
      st[0] <= nv[0];
    end
  end

  for (genvar r = 1; r <= MAX_PATTERN; r++) begin : g_cell
    if (r == 1) begin : g_first
      rdsm_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .step       (step),
        .enable     (len_sat >= LW'(r)),
        .has_prev   (1'b0),
        .pat_char   (pat_all[7:0]),
        .prev_char  (8'h00),
        .left_state (st[0]),
        .left2_next (1'b0),
        .state      (st[r]),
        .state_next (nv[r])
      );
    end else begin : g_rest
      rdsm_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .step       (step),
        .enable     (len_sat >= LW'(r)),
        .has_prev   (1'b1),
        .pat_char   (pat_all[8*(r-1) +: 8]),
        .prev_char  (pat_all[8*(r-2) +: 8]),
        .left_state (st[r-1]),
        .left2_next (nv[r-2]),
        .state      (st[r]),
        .state_next (nv[r])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step.fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      matched <= nv[len_sat];
    end
  end

  assign m_tdata = {7'd0, matched};

endmodule

>>> rtl/core/rdsm_checker.sv
module rdsm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed or dropped while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output register occupancy");

  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted word produced no result word");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    !(s_tvalid && s_tready) && m_tvalid && m_tready |=> !m_tvalid)
    else $error("result word repeated");

endmodule

bind regex_dot_star_matcher rdsm_checker u_rdsm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
